@@ rtl/core/dxc_pkg.sv @@
// Types and constants shared by the column decoder.
`timescale 1ns / 1ps

package dxc_pkg;

   // Column mode register codes; code 3 is unused and ignores data.
   typedef enum logic [1:0] {
      MODE_TSTAMP = 2'd0,
      MODE_ZIGZAG = 2'd1,
      MODE_XOR    = 2'd2
   } mode_type;

   localparam int unsigned VARINT_MAX_BYTES = 10;
   localparam int unsigned CTRL_VARINT_BIT  = 2;
   localparam int unsigned CNT_W            = 4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       column_start;
   } req_type;

   typedef struct packed {
      logic [63:0] value_bits;
      logic        overlong_error;
   } rsp_type;

endpackage

@@ rtl/core/delta_xor_column_decoder.sv @@
// Column decoder top level: varint delta, zigzag delta and xor-double decode.
`timescale 1ns / 1ps

// Decodes one compressed time-series column, one byte per req beat.
// req channel: req_data carries data_byte and column_start; a beat is taken
//   when req_valid is high and req_stall is low. column_start clears the
//   running value and the varint parser before its byte is used.
// rsp channel: one beat per completed value (value_bits, overlong_error);
//   the receiver holds it with rsp_stall, and the beat stays put until taken.
// csr port: csr_write_en writes csr_write_data into the column mode
//   (0 timestamp add, 1 zigzag add, 2 xor double, 3 ignore bytes). Write it
//   only while no beat is in flight.
// Timing: a byte is registered in the input register on acceptance, decoded
//   from there and its result lands in the rsp register, which drives
//   rsp_valid. One byte per cycle is sustained while no result waits under
//   rsp_stall; the loop is the 64-bit add/xor into the running value.
// Stall: while a result waits under rsp_stall the byte in the input register
//   holds, and req_stall rises only once that register is full too.
// Reset (synchronous, active high): mode returns to timestamp, all decode
//   state clears, both channels go empty.
module delta_xor_column_decoder
   import dxc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_write_en,
   input  logic [1:0] csr_write_data
);

   // xor word: ((payload << 2) | ctrl[1:0]) << (2 * ctrl[7:3])
   function automatic logic [63:0] xor_word(input logic [63:0] payload,
                                            input logic [7:0]  ctrl);
      logic [5:0]  sh;
      logic [63:0] base;
      sh   = {ctrl[7:3], 1'b0};
      base = {payload[61:0], ctrl[1:0]};
      return base << sh;
   endfunction

   // Control and config
   mode_type          mode_ff;
   logic              in_valid_ff, in_valid_in;
   req_type           in_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic              out_free;
   logic              process;

   // Decode state
   logic [63:0]       running_ff, running_in;
   logic [63:0]       partial_ff, partial_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [7:0]        ctrl_ff, ctrl_in;
   logic              expect_ff, expect_in;

   // Varint feed of the current byte
   logic [63:0]       base_part;
   logic [CNT_W-1:0]  base_cnt;
   logic [6:0]        shift;
   logic [63:0]       fed_part;
   logic [CNT_W-1:0]  fed_cnt;
   logic              more;
   logic              fed_done;
   logic [63:0]       delta;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign process     = in_valid_ff && out_free;
   assign req_stall   = in_valid_ff && !out_free;
   assign in_valid_in = process || !in_valid_ff ? req_valid : in_valid_ff;

   // column_start clears before the byte is used
   assign base_part = in_data_ff.column_start ? 64'd0 : partial_ff;
   assign base_cnt  = in_data_ff.column_start ? '0 : count_ff;
   assign shift     = {3'b000, base_cnt} * 7'd7;
   assign more      = in_data_ff.data_byte[7];
   assign fed_part  = (shift < 7'd64)
                      ? (base_part | ({57'd0, in_data_ff.data_byte[6:0]} << shift[5:0]))
                      : base_part;
   assign fed_cnt   = base_cnt + CNT_W'(1);
   assign fed_done  = !more || (fed_cnt >= CNT_W'(VARINT_MAX_BYTES));

   always_comb begin
      running_in   = in_data_ff.column_start ? 64'd0 : running_ff;
      partial_in   = base_part;
      count_in     = base_cnt;
      ctrl_in      = in_data_ff.column_start ? 8'd0 : ctrl_ff;
      expect_in    = in_data_ff.column_start ? 1'b0 : expect_ff;
      rsp_valid_in = 1'b0;
      delta        = fed_part;
      case (mode_ff)
         MODE_TSTAMP, MODE_ZIGZAG: begin
            partial_in = fed_done ? 64'd0 : fed_part;
            count_in   = fed_done ? '0 : fed_cnt;
            if (fed_done) begin
               if (mode_ff == MODE_ZIGZAG) begin
                  delta = (fed_part >> 1) ^ {64{fed_part[0]}};
               end
               running_in   = running_in + delta;
               rsp_valid_in = 1'b1;
            end
         end
         MODE_XOR: begin
            if (expect_in) begin
               partial_in = fed_done ? 64'd0 : fed_part;
               count_in   = fed_done ? '0 : fed_cnt;
               if (fed_done) begin
                  expect_in    = 1'b0;
                  running_in   = running_in ^ xor_word(fed_part, ctrl_in);
                  rsp_valid_in = 1'b1;
               end
            end else begin
               ctrl_in    = in_data_ff.data_byte;
               partial_in = 64'd0;
               count_in   = '0;
               if (in_data_ff.data_byte[CTRL_VARINT_BIT]) begin
                  expect_in = 1'b1;
               end else begin
                  running_in   = running_in ^ xor_word(64'd0, in_data_ff.data_byte);
                  rsp_valid_in = 1'b1;
               end
            end
         end
         default: begin
            // unused mode: bytes ignored, only column_start takes effect
         end
      endcase
      rsp_data_in.value_bits     = running_in;
      // overlong only on a varint cut off with its continuation bit still set
      rsp_data_in.overlong_error = more && (mode_ff != MODE_XOR || expect_ff
                                   && !in_data_ff.column_start);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_TSTAMP;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         running_ff   <= 64'd0;
         partial_ff   <= 64'd0;
         count_ff     <= '0;
         ctrl_ff      <= 8'd0;
         expect_ff    <= 1'b0;
      end else begin
         if (csr_write_en) begin
            mode_ff <= mode_type'(csr_write_data);
         end
         in_valid_ff <= in_valid_in;
         if (process) begin
            rsp_valid_ff <= rsp_valid_in;
            running_ff   <= running_in;
            partial_ff   <= partial_in;
            count_ff     <= count_in;
            ctrl_ff      <= ctrl_in;
            expect_ff    <= expect_in;
         end else if (out_free) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!in_valid_ff || process) begin
         in_data_ff <= req_data;
      end
      if (process) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Varint parser never holds ten or more bytes.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff < CNT_W'(VARINT_MAX_BYTES))
      else $error("varint byte count out of range");

   // Input side only pushes back when a byte is already held.
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("req_stall without a held byte");

   // A blocked result freezes the decode state.
   a_state_frozen: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(running_ff) && $stable(count_ff))
      else $error("decode state moved under a stalled result");

   // The unused mode never yields a result.
   a_mode3_quiet: assert property (@(posedge clock) disable iff (reset)
      (process && mode_ff != MODE_TSTAMP && mode_ff != MODE_ZIGZAG
       && mode_ff != MODE_XOR) |=> !rsp_valid_ff)
      else $error("result produced in unused mode");

endmodule
